// ===== sv/atan_pkg.sv =====
`default_nettype none

package atan_pkg;

    // Default vector component width
    localparam int COORD_WIDTH_DEF = 16;

    // Angle result width and quotient width (quotient spans 0..256)
    localparam int ANGLE_WIDTH = 9;
    localparam int QUOT_BITS   = 9;
    localparam int OCT_WIDTH   = 6;
    localparam int NUM_BOUNDS  = 45;

    // Fixed angles in whole degrees
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_0   = 9'd0;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_90  = 9'd90;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_180 = 9'd180;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_270 = 9'd270;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_360 = 9'd360;

    // Smallest quotient that rounds up past each half degree d+0.5
    localparam logic [QUOT_BITS-1:0] HALF_DEG_BOUNDS [NUM_BOUNDS] = '{
        9'd3,   9'd7,   9'd12,  9'd16,  9'd21,  9'd25,  9'd30,  9'd34,  9'd39,
        9'd43,  9'd48,  9'd53,  9'd57,  9'd62,  9'd67,  9'd71,  9'd76,  9'd81,
        9'd86,  9'd91,  9'd96,  9'd101, 9'd107, 9'd112, 9'd117, 9'd123, 9'd128,
        9'd134, 9'd139, 9'd145, 9'd151, 9'd157, 9'd164, 9'd170, 9'd176, 9'd183,
        9'd190, 9'd197, 9'd204, 9'd212, 9'd219, 9'd227, 9'd235, 9'd243, 9'd252
    };

    // Side information that travels with each vector through the divider
    typedef struct packed {
        logic                   on_axis;
        logic [ANGLE_WIDTH-1:0] axis_angle;
        logic                   swap;
        logic                   x_neg;
        logic                   y_neg;
    } t_meta;

    // First-octant angle in degrees, 0..45, for ratio index q/256
    // Bounds rise monotonically, so the highest bound passed gives the count
    function automatic logic [OCT_WIDTH-1:0] octant_angle(input logic [QUOT_BITS-1:0] q);
        logic [OCT_WIDTH-1:0] cnt;
        cnt = '0;
        for (int d = 0; d < NUM_BOUNDS; d++) begin
            if (q >= HALF_DEG_BOUNDS[d]) begin
                cnt = OCT_WIDTH'(d + 1);
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

// ===== sv/atan_in_if.sv =====
`default_nettype none

interface atan_in_if
    import atan_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] x_coord;

    modport source (output valid, output y_coord, output x_coord, input ready);
    modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

`default_nettype wire

// ===== sv/atan_out_if.sv =====
`default_nettype none

interface atan_out_if
    import atan_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [ANGLE_WIDTH-1:0] angle_deg;

    modport source (output valid, output angle_deg, input ready);
    modport sink   (input valid, input angle_deg, output ready);
endinterface

`default_nettype wire

// ===== sv/atan_div_cell.sv =====
`default_nettype none

module atan_div_cell
    import atan_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_valid,
    input  wire logic [COORD_WIDTH:0]   i_rem,
    input  wire logic [COORD_WIDTH-1:0] i_div,
    input  wire logic [QUOT_BITS-1:0]   i_quot,
    input  wire t_meta                  i_meta,
    output logic                        o_valid,
    output logic [COORD_WIDTH:0]        o_rem,
    output logic [COORD_WIDTH-1:0]      o_div,
    output logic [QUOT_BITS-1:0]        o_quot,
    output t_meta                       o_meta
);

    logic                   ge;
    logic [COORD_WIDTH-1:0] diff;
    logic [COORD_WIDTH:0]   n_rem;
    logic                   r_valid;
    logic [COORD_WIDTH:0]   r_rem;
    logic [COORD_WIDTH-1:0] r_div;
    logic [QUOT_BITS-1:0]   r_quot;
    t_meta                  r_meta;

    // Restoring step: one quotient bit, then shift the partial remainder
    always_comb begin
        ge    = (i_rem >= {1'b0, i_div});
        diff  = ge ? COORD_WIDTH'(i_rem - {1'b0, i_div}) : i_rem[COORD_WIDTH-1:0];
        n_rem = {diff, 1'b0};
    end

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Hand the working values to the next cell
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_quot <= {i_quot[QUOT_BITS-2:0], ge};
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quot  = r_quot;
    assign o_meta  = r_meta;

endmodule

`default_nettype wire

// ===== sv/atan_angle_stage.sv =====
`default_nettype none

module atan_angle_stage
    import atan_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire logic                 i_valid,
    input  wire logic [QUOT_BITS-1:0] i_quot,
    input  wire t_meta                i_meta,
    output logic                      o_valid,
    output logic [ANGLE_WIDTH-1:0]    o_angle
);

    logic [ANGLE_WIDTH-1:0] oct;
    logic [ANGLE_WIDTH-1:0] first_quad;
    logic [ANGLE_WIDTH-1:0] n_angle;
    logic                   r_valid;
    logic [ANGLE_WIDTH-1:0] r_angle;

    // Look up the octant angle, mirror it, then place it in its quadrant; axis vectors take their fixed angle
    always_comb begin
        oct        = ANGLE_WIDTH'(octant_angle(i_quot));
        first_quad = i_meta.swap ? (ANGLE_90 - oct) : oct;
        if (i_meta.on_axis) begin
            n_angle = i_meta.axis_angle;
        end else if (i_meta.x_neg && !i_meta.y_neg) begin
            n_angle = ANGLE_180 - first_quad;
        end else if (i_meta.x_neg && i_meta.y_neg) begin
            n_angle = ANGLE_180 + first_quad;
        end else if (!i_meta.x_neg && i_meta.y_neg) begin
            n_angle = ANGLE_360 - first_quad;
        end else begin
            n_angle = first_quad;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ===== sv/atan2_degrees_lookup.sv =====
// Whole-degree angle of a signed vector (x, y), counterclockwise from +x.
//
// Input channel i_in carries y_coord and x_coord; output channel o_out carries
// angle_deg (0..360, 360 is not wrapped to 0). A transfer happens on a rising
// edge with valid and ready both high. Vectors on an axis get exact answers.
//
// One vector enters every cycle while the receiver keeps up. The path is an
// input register that forms the magnitudes, a chain of 9 divider cells that
// each produce one bit of the 256*min/max quotient, and an output register
// that applies the arctangent table and the quadrant fix-up.
//
// When the receiver stalls with a result waiting, the whole chain holds and
// i_in.ready drops in the same cycle; nothing moves until that result is
// taken. Reset empties all stages.
`default_nettype none

module atan2_degrees_lookup
    import atan_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    atan_in_if.sink   i_in,
    atan_out_if.source o_out
);

    logic                   adv;
    logic [COORD_WIDTH-1:0] x_u;
    logic [COORD_WIDTH-1:0] y_u;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic                   x_zero;
    logic                   y_zero;
    t_meta                  n_meta;

    logic                   s_valid [QUOT_BITS+1];
    logic [COORD_WIDTH:0]   s_rem   [QUOT_BITS+1];
    logic [COORD_WIDTH-1:0] s_div   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]   s_quot  [QUOT_BITS+1];
    t_meta                  s_meta  [QUOT_BITS+1];

    logic                   r_valid;
    logic [COORD_WIDTH:0]   r_rem;
    logic [COORD_WIDTH-1:0] r_div;
    t_meta                  r_meta;

    logic                   out_valid;
    logic [ANGLE_WIDTH-1:0] out_angle;

    // Advance the whole chain unless a result sits unclaimed
    assign adv        = !out_valid || o_out.ready;
    assign i_in.ready = adv;

    // Form magnitudes, order them and classify axis cases
    always_comb begin
        x_u    = i_in.x_coord;
        y_u    = i_in.y_coord;
        ax     = x_u[COORD_WIDTH-1] ? (~x_u + COORD_WIDTH'(1)) : x_u;
        ay     = y_u[COORD_WIDTH-1] ? (~y_u + COORD_WIDTH'(1)) : y_u;
        x_zero = (x_u == '0);
        y_zero = (y_u == '0);

        n_meta.x_neg   = x_u[COORD_WIDTH-1];
        n_meta.y_neg   = y_u[COORD_WIDTH-1];
        n_meta.swap    = (ay > ax);
        n_meta.on_axis = x_zero || y_zero;
        if (x_zero && y_zero) begin
            n_meta.axis_angle = ANGLE_0;
        end else if (x_zero) begin
            n_meta.axis_angle = y_u[COORD_WIDTH-1] ? ANGLE_270 : ANGLE_90;
        end else if (x_u[COORD_WIDTH-1]) begin
            n_meta.axis_angle = ANGLE_180;
        end else begin
            n_meta.axis_angle = ANGLE_0;
        end
    end

    // Input register: smaller magnitude is the dividend, larger the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem  <= {1'b0, (n_meta.swap ? ax : ay)};
            r_div  <= n_meta.swap ? ay : ax;
            r_meta <= n_meta;
        end
    end

    assign s_valid[0] = r_valid;
    assign s_rem[0]   = r_rem;
    assign s_div[0]   = r_div;
    assign s_quot[0]  = '0;
    assign s_meta[0]  = r_meta;

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
        atan_div_cell #(
            .COORD_WIDTH(COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (s_valid[k]),
            .i_rem   (s_rem[k]),
            .i_div   (s_div[k]),
            .i_quot  (s_quot[k]),
            .i_meta  (s_meta[k]),
            .o_valid (s_valid[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_div   (s_div[k+1]),
            .o_quot  (s_quot[k+1]),
            .o_meta  (s_meta[k+1])
        );
    end

    atan_angle_stage u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (s_valid[QUOT_BITS]),
        .i_quot  (s_quot[QUOT_BITS]),
        .i_meta  (s_meta[QUOT_BITS]),
        .o_valid (out_valid),
        .o_angle (out_angle)
    );

    assign o_out.valid     = out_valid;
    assign o_out.angle_deg = out_angle;

    // The angle never exceeds a full turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_angle <= ANGLE_360))
        else $error("angle out of range");

    // A vector leaving the last cell lands in the output register
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && s_valid[QUOT_BITS]) |=> out_valid)
        else $error("result lost between divider and output");

    // The quotient never exceeds 256
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_valid[QUOT_BITS] && !s_meta[QUOT_BITS].on_axis)
            |-> (s_quot[QUOT_BITS] <= QUOT_BITS'(256)))
        else $error("quotient out of range");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
